### src/fxa_pkg.sv
// package for the q24.8 fixed-point alu: payload structs, operation codes, status codes
// no dependencies
package fxa_pkg;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int WORD_W = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_raw;
    logic               compare_true;
    logic [1:0]         status;
  } out_item_t;
endpackage

### src/fxa_core.sv
// pipelined datapath: operand prep, multiply, shift-subtract divide stages, rounding
// depends on fxa_pkg
module fxa_core import fxa_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_vld,
  input  in_item_t  in_item,
  output logic      out_vld,
  output out_item_t out_item
);
  // quotient bits of 2*|a|*2^F / (2*|b|), enough to cover saturation
  localparam int NW  = 32 + FRACTION_BITS + 1;
  localparam int QW  = NW;
  localparam int DS  = QW;
  localparam int NS  = DS + 2;

  typedef struct packed {
    logic [3:0]  kind;
    logic        neg;
    logic        dz;
    logic [31:0] fin;
    logic        cmp;
    logic [1:0]  st;
  } ctl_t;

  // stage 0: prep
  ctl_t        c0_r;
  logic        v0_r;
  logic [31:0] ma0_r, mb0_r;
  logic [NW-1:0] num0_r;
  logic [33:0] den0_r;

  logic signed [32:0] sum_w, dif_w;
  logic [31:0] aa, ab;
  ctl_t c0_nxt;
  always_comb begin
    aa = in_item.operand_a[31] ? 32'(-in_item.operand_a) : in_item.operand_a;
    ab = in_item.operand_b[31] ? 32'(-in_item.operand_b) : in_item.operand_b;
    sum_w = 33'(in_item.operand_a) + 33'(in_item.operand_b);
    dif_w = 33'(in_item.operand_a) - 33'(in_item.operand_b);
    c0_nxt = '0;
    c0_nxt.kind = in_item.kind;
    c0_nxt.neg = in_item.operand_a[31] ^ in_item.operand_b[31];
    c0_nxt.dz = (in_item.operand_b == 0);
    case (in_item.kind) inside
      OP_ADD, OP_SUB: begin
        if (in_item.kind == OP_ADD) c0_nxt.fin = sum_w[31:0];
        else c0_nxt.fin = dif_w[31:0];
        if (in_item.kind == OP_ADD && sum_w[32] != sum_w[31]) begin
          c0_nxt.st = ST_SAT;
          c0_nxt.fin = sum_w[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        if (in_item.kind == OP_SUB && dif_w[32] != dif_w[31]) begin
          c0_nxt.st = ST_SAT;
          c0_nxt.fin = dif_w[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
      end
      OP_GT: c0_nxt.cmp = in_item.operand_a > in_item.operand_b;
      OP_LT: c0_nxt.cmp = in_item.operand_a < in_item.operand_b;
      OP_GE: c0_nxt.cmp = in_item.operand_a >= in_item.operand_b;
      OP_LE: c0_nxt.cmp = in_item.operand_a <= in_item.operand_b;
      OP_EQ: c0_nxt.cmp = in_item.operand_a == in_item.operand_b;
      OP_NE: c0_nxt.cmp = in_item.operand_a != in_item.operand_b;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_vld;
    if (adv) begin
      c0_r <= c0_nxt;
      ma0_r <= aa;
      mb0_r <= ab;
      // numerator 2*|a|*2^F, denominator 2*|b|
      num0_r <= {aa, {FRACTION_BITS{1'b0}}, 1'b0};
      den0_r <= {1'b0, ab, 1'b0};
    end
  end

  // stage 1: multiply (split 32x16 partials, registered)
  logic [47:0] pl1_r, ph1_r;
  ctl_t        c1_r;
  logic        v1_r;
  logic [NW-1:0] num1_r;
  logic [33:0] den1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= v0_r;
    if (adv) begin
      pl1_r <= ma0_r * mb0_r[15:0];
      ph1_r <= ma0_r * mb0_r[31:16];
      c1_r <= c0_r;
      num1_r <= num0_r;
      den1_r <= den0_r;
    end
  end

  // divider stages: one quotient bit per stage, restoring
  logic [NS-1:0]   vs_r;
  ctl_t            cs_r   [DS+1];
  logic [33:0]     dn_r   [DS+1];
  logic [NW-1:0]   nm_r   [DS+1];
  logic [34:0]     rm_r   [DS+1];
  logic [QW-1:0]   qt_r   [DS+1];
  logic [63:0]     pr_r   [DS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= '0;
    else if (adv) vs_r <= {vs_r[NS-2:0], v1_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r[0] <= c1_r;
      dn_r[0] <= den1_r;
      nm_r[0] <= num1_r;
      rm_r[0] <= '0;
      qt_r[0] <= '0;
      pr_r[0] <= 64'(pl1_r) + {ph1_r, 16'h0};
    end
  end

  for (genvar i = 0; i < DS; i++) begin : g_div
    logic [34:0] t;
    logic [35:0] d;
    always_comb begin
      t = {rm_r[i][33:0], nm_r[i][NW-1]};
      d = {1'b0, t} - {2'b0, dn_r[i]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        cs_r[i+1] <= cs_r[i];
        dn_r[i+1] <= dn_r[i];
        nm_r[i+1] <= nm_r[i] << 1;
        pr_r[i+1] <= pr_r[i];
        rm_r[i+1] <= d[35] ? t : d[34:0];
        qt_r[i+1] <= {qt_r[i][QW-2:0], ~d[35]};
      end
    end
  end

  // rounding stage: division quotient q = floor((2n)/(2d)) with +d folded in below
  // (2n+d)/(2d): add half divisor via remainder compare
  logic [QW:0]  dq_w;
  logic [64:0]  mm_w;
  logic [64:0]  mag_w;
  logic [31:0]  res_w;
  logic [1:0]   st_w;
  logic         extra;
  ctl_t         cl;
  always_comb begin
    cl = cs_r[DS];
    // rem of 2n mod 2d plus d >= 2d  <=> rem >= d
    extra = ({1'b0, rm_r[DS]} >= {2'b0, dn_r[DS][33:1]});
    dq_w = {1'b0, qt_r[DS]} + (QW+1)'(extra);
    mm_w = ({1'b0, pr_r[DS]} + (65'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    mag_w = (cl.kind == OP_MUL) ? mm_w : 65'(dq_w);
    st_w = cl.st;
    res_w = cl.fin;
    if (cl.kind == OP_MUL || cl.kind == OP_DIV) begin
      st_w = ST_OK;
      if (cl.kind == OP_DIV && cl.dz) begin
        res_w = '0;
        st_w = ST_DIV0;
      end else if (cl.neg && mag_w != 0) begin
        if (mag_w > 65'h8000_0000) begin
          st_w = ST_SAT;
          res_w = 32'h8000_0000;
        end else res_w = 32'(-mag_w[31:0]);
      end else begin
        if (mag_w > 65'h7fff_ffff) begin
          st_w = ST_SAT;
          res_w = 32'h7fff_ffff;
        end else res_w = mag_w[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.result_raw <= res_w;
      out_item.compare_true <= cl.cmp;
      out_item.status <= st_w;
    end
  end
  assign out_vld = vs_r[NS-1];
endmodule

### src/fixed_point_q24_8_alu_unit.sv
// top level of the q24.8 fixed-point alu: handshake and output skid buffer
// depends on fxa_pkg and fxa_core
// usage: in_valid/in_ready carry an in_item_t (kind, operand_a, operand_b);
// out_valid/out_ready carry an out_item_t (result_raw, compare_true, status).
// one item enters per cycle; every item yields exactly one result in order.
// the pipe depth is set by the restoring divider that retires one quotient
// bit per stage; add, compare and multiply travel the same pipe so order
// holds. throughput is one transfer per cycle. when the receiver stalls the
// whole pipe holds once the two-entry output buffer is full, or holds one
// result while another leaves the core; while the buffer has room or is
// being read the pipe moves, so in_ready follows it.
// reset (rst_n low, synchronous) drops every item in flight and empties
// the buffer; data registers are not cleared.
module fixed_point_q24_8_alu_unit import fxa_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  logic      adv, cv;
  out_item_t cd;
  out_item_t b0_r, b1_r;
  logic [1:0] cnt_r;
  logic push, pop;

  // advance when buffer has room for whatever leaves the core
  assign adv = (cnt_r == 2'd0) || (cnt_r == 2'd1 && !cv) || pop;
  assign in_ready = adv;

  fxa_core #(.FRACTION_BITS(FRACTION_BITS)) u_core (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_vld(in_valid),
    .in_item(in_data), .out_vld(cv), .out_item(cd)
  );

  assign pop = out_valid && out_ready;
  assign push = adv && cv;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data = b0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_r + 2'(push) - 2'(pop);
    if (pop) begin
      b0_r <= (cnt_r == 2'd2) ? b1_r : cd;
      if (push && cnt_r == 2'd2) b1_r <= cd;
    end else if (push) begin
      if (cnt_r == 2'd0) b0_r <= cd;
      else b1_r <= cd;
    end
  end
endmodule

### bench/fxa_checker.sv
// checker for the q24.8 fixed-point alu: watches both channels, predicts each result
// depends on fxa_pkg
`timescale 1ns / 1ps
module fxa_checker import fxa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        result_count
);
  localparam int FB = FRACTION_BITS_DEF;

  out_item_t expected_q[$];
  int errs = 0;
  int seen = 0;
  int pend = 0;

  function automatic logic [31:0] sign_mag_sat(input bit neg, input logic [63:0] mag,
                                               inout logic [1:0] st);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        st = ST_SAT;
        mag = 64'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > 64'h7fff_ffff) begin
      st = ST_SAT;
      mag = 64'h7fff_ffff;
    end
    return mag[31:0];
  endfunction

  function automatic logic [31:0] clamp_word(input logic signed [63:0] v,
                                             inout logic [1:0] st);
    if (v > 64'sd2147483647) begin
      st = ST_SAT;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      st = ST_SAT;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic out_item_t alu_predict(input in_item_t it);
    out_item_t r;
    logic signed [63:0] a, b;
    logic [63:0] ma, mb, mag, num;
    bit neg;
    a = it.operand_a;
    b = it.operand_b;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    r = '0;
    r.status = ST_OK;
    case (it.kind)
      OP_ADD: r.result_raw = clamp_word(a + b, r.status);
      OP_SUB: r.result_raw = clamp_word(a - b, r.status);
      OP_MUL: begin
        mag = (ma * mb + (64'd1 << (FB - 1))) >> FB;
        r.result_raw = sign_mag_sat(neg && mag != 0, mag, r.status);
      end
      OP_DIV: begin
        if (b == 0) r.status = ST_DIV0;
        else begin
          num = ma << FB;
          mag = (2 * num + mb) / (2 * mb);
          r.result_raw = sign_mag_sat(neg && mag != 0, mag, r.status);
        end
      end
      OP_GT: r.compare_true = a > b;
      OP_LT: r.compare_true = a < b;
      OP_GE: r.compare_true = a >= b;
      OP_LE: r.compare_true = a <= b;
      OP_EQ: r.compare_true = a == b;
      OP_NE: r.compare_true = a != b;
      default: ;
    endcase
    return r;
  endfunction

  assign fail_count = errs;
  assign result_count = seen;
  assign pending = pend;

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (in_valid && in_ready) expected_q.push_back(alu_predict(in_data));
      if (out_valid && out_ready) begin
        seen = seen + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer %h", out_data);
          errs = errs + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.result_raw !== out_data.result_raw) begin
            $error("result_raw expected %h actual %h", e.result_raw, out_data.result_raw);
            errs = errs + 1;
          end
          if (e.compare_true !== out_data.compare_true) begin
            $error("compare_true expected %b actual %b", e.compare_true,
                   out_data.compare_true);
            errs = errs + 1;
          end
          if (e.status !== out_data.status) begin
            $error("status expected %0d actual %0d", e.status, out_data.status);
            errs = errs + 1;
          end
        end
      end
      pend = expected_q.size();
    end
  end
endmodule

### bench/tb.sv
// testbench top for the q24.8 fixed-point alu: stimulus, receiver stalls, verdict
// depends on fxa_pkg, fxa_checker and fixed_point_q24_8_alu_unit
`timescale 1ns / 1ps
module tb;
  import fxa_pkg::*;

  localparam int LATENCY = FRACTION_BITS_DEF + 38;
  localparam int N_RANDOM = 1030;
  localparam int STALL_LIMIT = 5000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  in_item_t in_data = '0;
  logic in_ready, out_valid;
  out_item_t out_data;
  int fail_count, pending, result_count;
  int idle_cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  fixed_point_q24_8_alu_unit dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  fxa_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .fail_count, .pending, .result_count
  );

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'($urandom_range(0, 4095)) << 8;
      4: return -(32'($urandom_range(0, 4095)) << 8);
      5: return 32'(int'($urandom_range(0, 131071)) - 65536);
      default: return $urandom();
    endcase
  endfunction

  task automatic send(input logic [3:0] k, input logic [31:0] a, input logic [31:0] b);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    repeat (gap) @(negedge clk);
    in_data.kind = k;
    in_data.operand_a = a;
    in_data.operand_b = b;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
  endtask

  // receiver stalls, with a stall-free stretch in the middle
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (result_count > 300 && result_count < 450) w = 0;
      else w = $urandom_range(0, 14);
      out_ready = 0;
      repeat (w) @(negedge clk);
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [3:0] k;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    send(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
    send(OP_ADD, 32'h8000_0000, 32'hffff_ffff);
    send(OP_SUB, 32'h8000_0000, 32'h0000_0001);
    send(OP_SUB, 32'h7fff_ffff, 32'h8000_0000);
    send(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send(OP_MUL, 32'h8000_0000, 32'h0000_0100);
    send(OP_MUL, 32'h0000_0001, 32'h0000_0080);
    send(OP_MUL, 32'hffff_ffff, 32'h0000_0080);
    send(OP_MUL, 32'h0000_0180, 32'hffff_fe80);
    send(OP_DIV, 32'h0000_0100, 32'h0000_0000);
    send(OP_DIV, 32'h8000_0000, 32'hffff_ff00);
    send(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
    send(OP_DIV, 32'h0000_0001, 32'h0000_0200);
    send(OP_DIV, 32'hffff_ffff, 32'h0000_0200);
    send(OP_GT, 32'h8000_0000, 32'h7fff_ffff);
    send(OP_LT, 32'h8000_0000, 32'h7fff_ffff);
    send(OP_GE, 32'h0000_0005, 32'h0000_0005);
    send(OP_LE, 32'hffff_ffff, 32'h0000_0000);
    send(OP_EQ, 32'h1234_5678, 32'h1234_5678);
    send(OP_NE, 32'h1234_5678, 32'h1234_5678);
    send(4'd10, 32'hffff_ffff, 32'hffff_ffff);
    send(4'd15, 32'h0000_0000, 32'h0000_0000);
    // drain once with the sender held off
    while (pending != 0) @(negedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      k = $urandom_range(0, 12) < 12 ? 4'($urandom_range(0, 9)) : 4'($urandom_range(10, 15));
      send(k, pick_word(), $urandom_range(0, 19) == 0 ? 32'h0 : pick_word());
    end
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    $display("covered %0d results over all ten operations, unused codes,", result_count);
    $display("saturation, rounding ties and divide by zero under random stalls");
    if (fail_count == 0 && pending == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
